@@ rtl/bmof_pkg.sv @@
package bmof_pkg;

  // default geometry
  localparam int GROUP_SIZE_DEF  = 5;
  localparam int SAMPLE_BITS_DEF = 16;

  // threshold register, in hundredths
  localparam int                   THR_BITS  = 10;
  localparam logic [THR_BITS-1:0]  THR_RESET = THR_BITS'(110);
  localparam int                   TT_BITS   = 2 * THR_BITS;

  // scale of the left side of the outlier test (percent squared)
  localparam int K_SCALE = 10000;

  // multiplier digit width, one digit per cycle
  localparam int DIGIT_BITS = 16;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // per item flags carried from front to back
  typedef struct packed {
    logic eos;
    logic close;
  } item_flags_t;

  // result side flags, replaced in the lowest bit
  typedef struct packed {
    logic stream_done;
    logic replaced;
  } out_user_t;

endpackage

@@ rtl/bmof_front.sv @@
module bmof_front #(
  parameter int GROUP_SIZE  = bmof_pkg::GROUP_SIZE_DEF,
  parameter int SAMPLE_BITS = bmof_pkg::SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_BITS-1:0]  in_sample,
  input  logic                    in_eos,
  output logic                    push,
  output logic [SAMPLE_BITS-1:0]  push_sample,
  output bmof_pkg::item_flags_t   push_flags,
  input  logic                    q_full
);

  localparam int IW = $clog2(GROUP_SIZE);

  logic [IW-1:0] fill_count;
  logic          accept;
  logic          closing;

  // take an item whenever the queue has room
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // a group closes on a full group or on the end of the stream
  assign closing = in_eos || (fill_count == IW'(GROUP_SIZE - 1));

  assign push             = accept;
  assign push_sample      = in_sample;
  assign push_flags.eos   = in_eos;
  assign push_flags.close = closing;

  // position inside the open group
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= closing ? '0 : fill_count + IW'(1);
    end
  end

endmodule

@@ rtl/bmof_fifo.sv @@
module bmof_fifo #(
  parameter int WIDTH = bmof_pkg::SAMPLE_BITS_DEF + 2,
  parameter int DEPTH = bmof_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/bmof_mul.sv @@
module bmof_mul #(
  parameter int A_BITS = 40,
  parameter int B_BITS = 20
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [A_BITS-1:0]        a,
  input  logic [B_BITS-1:0]        b,
  output logic                     busy,
  output logic                     done,
  output logic [A_BITS+B_BITS-1:0] product
);

  localparam int DW       = bmof_pkg::DIGIT_BITS;
  localparam int NDIG     = (B_BITS + DW - 1) / DW;
  localparam int BP       = NDIG * DW;
  localparam int ACC_BITS = A_BITS + BP;
  localparam int P_BITS   = A_BITS + B_BITS;
  localparam int SW       = $clog2(NDIG + 1);

  logic [A_BITS-1:0]    a_r;
  logic [BP-1:0]        b_r;
  logic [ACC_BITS-1:0]  acc;
  logic [ACC_BITS-1:0]  acc_next;
  logic [A_BITS+DW-1:0] partial;
  logic [SW-1:0]        steps;

  // horner step: most significant digit of b first
  assign partial  = a_r * b_r[BP-1 -: DW];
  assign acc_next = {acc[ACC_BITS-DW-1:0], {DW{1'b0}}} + ACC_BITS'(partial);
  assign product  = acc[P_BITS-1:0];

  // operand and accumulator registers
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= BP'(b);
      acc <= '0;
    end else if (busy) begin
      acc <= acc_next;
      b_r <= b_r << DW;
    end
  end

  // digit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= SW'(NDIG);
      end else if (busy) begin
        steps <= steps - SW'(1);
        if (steps == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/bmof_back.sv @@
module bmof_back #(
  parameter int GROUP_SIZE  = bmof_pkg::GROUP_SIZE_DEF,
  parameter int SAMPLE_BITS = bmof_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bmof_pkg::THR_BITS-1:0] cfg_data,
  input  logic                          q_empty,
  input  logic [SAMPLE_BITS-1:0]        q_sample,
  input  bmof_pkg::item_flags_t         q_flags,
  output logic                          q_pop,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [SAMPLE_BITS-1:0]        out_value,
  output logic                          out_last,
  output bmof_pkg::out_user_t           out_user
);

  localparam int SB       = SAMPLE_BITS;
  localparam int IW       = $clog2(GROUP_SIZE);
  localparam int CW       = $clog2(GROUP_SIZE + 1);
  localparam int SUM_BITS = SB + CW;
  localparam int SQ_BITS  = 2 * SB;
  localparam int SSQ_BITS = 2 * SB + CW;
  localparam int VW       = 2 * SB + 2 * CW;
  localparam int NN_BITS  = 2 * CW;
  localparam int KW       = $clog2(bmof_pkg::K_SCALE * GROUP_SIZE * GROUP_SIZE + 1);
  localparam int B0       = (SUM_BITS > bmof_pkg::TT_BITS) ? SUM_BITS : bmof_pkg::TT_BITS;
  localparam int B_BITS   = (B0 > KW) ? B0 : KW;
  localparam int A_BITS   = VW;
  localparam int P_BITS   = A_BITS + B_BITS;

  typedef enum logic [3:0] {
    S_LOAD,
    S_FLUSH,
    S_MUL_SS,
    S_MUL_NQ,
    S_VAR,
    S_MUL_RHS,
    S_SQ,
    S_MUL_LHS,
    S_EMIT
  } state_t;

  state_t state;

  // group storage: arrival order and insertion sorted
  logic [SB-1:0] grp_mem  [GROUP_SIZE];
  logic [SB-1:0] sorted_q [GROUP_SIZE];
  logic [SB-1:0] sorted_next [GROUP_SIZE];
  logic [GROUP_SIZE-1:0] gt;
  logic [GROUP_SIZE-1:0] gt_prev;

  logic [IW-1:0]       cnt;
  logic [IW-1:0]       idx;
  logic [CW-1:0]       n_r;
  logic                eos_r;
  logic [SUM_BITS-1:0] sum_r;
  logic [SSQ_BITS-1:0] sumsq_r;
  logic [SQ_BITS-1:0]  sq_r;
  logic [SB-1:0]       sq_in;
  logic                sq_en;
  logic                sq_add;
  logic                sq_first;
  logic [SB-1:0]       med_r;
  logic [IW-1:0]       med_idx;
  logic [NN_BITS-1:0]  nn_r;
  logic [KW-1:0]       k_r;
  logic [bmof_pkg::TT_BITS-1:0]  tt_r;
  logic [bmof_pkg::THR_BITS-1:0] thr_r;
  logic [VW-1:0]       ss_r;
  logic [VW-1:0]       nq_r;
  logic [VW-1:0]       var_r;
  logic [P_BITS-1:0]   rhs_r;
  logic                rep_r;

  logic [SB-1:0]       x_cur;
  logic [SB-1:0]       d_cur;
  logic                last_cur;
  logic                emit_go;
  logic                mul_state;
  logic                mul_issued;
  logic                mul_start;
  logic                mul_busy;
  logic                mul_done;
  logic [A_BITS-1:0]   mul_a;
  logic [B_BITS-1:0]   mul_b;
  logic [P_BITS-1:0]   mul_p;

  assign cfg_ready = 1'b1;
  assign q_pop     = (state == S_LOAD) && !q_empty;
  assign med_idx   = IW'(n_r >> 1);
  assign x_cur     = grp_mem[idx];
  assign d_cur     = (x_cur > med_r) ? x_cur - med_r : med_r - x_cur;
  assign last_cur  = ((CW'(idx) + CW'(1)) == n_r);
  assign emit_go   = (state == S_EMIT) && (!out_valid || out_ready);

  // squarer input: sample while loading, distance to median while testing
  assign sq_in = (state == S_LOAD) ? q_sample : d_cur;
  assign sq_en = q_pop || (state == S_SQ);

  // insertion into the sorted row, one sample per cycle while loading from a non-empty queue
  always_comb begin
    for (int j = 0; j < GROUP_SIZE; j++) begin
      gt[j] = (IW'(j) < cnt) && (sorted_q[j] > q_sample);
    end
    gt_prev = gt << 1;
    for (int j = 0; j < GROUP_SIZE; j++) begin
      if (gt_prev[j]) begin
        sorted_next[j] = sorted_q[(j + GROUP_SIZE - 1) % GROUP_SIZE];
      end else if (gt[j] || (IW'(j) == cnt)) begin
        sorted_next[j] = q_sample;
      end else begin
        sorted_next[j] = sorted_q[j];
      end
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_state = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      S_MUL_SS: begin
        mul_a = A_BITS'(sum_r);
        mul_b = B_BITS'(sum_r);
      end
      S_MUL_NQ: begin
        mul_a = A_BITS'(sumsq_r);
        mul_b = B_BITS'(n_r);
      end
      S_MUL_RHS: begin
        mul_a = var_r;
        mul_b = B_BITS'(tt_r);
      end
      S_MUL_LHS: begin
        mul_a = A_BITS'(sq_r);
        mul_b = B_BITS'(k_r);
      end
      default: begin
        mul_state = 1'b0;
      end
    endcase
  end

  assign mul_start = mul_state && !mul_issued;

  bmof_mul #(
    .A_BITS (A_BITS),
    .B_BITS (B_BITS)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (mul_p)
  );

  // group storage writes
  always_ff @(posedge clk) begin
    if (q_pop) begin
      grp_mem[cnt] <= q_sample;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        sorted_q[j] <= sorted_next[j];
      end
    end
  end

  // running sum and sum of squares
  always_ff @(posedge clk) begin
    if (sq_en) begin
      sq_r <= sq_in * sq_in;
    end
    if (q_pop) begin
      sum_r <= (cnt == '0) ? SUM_BITS'(q_sample) : sum_r + SUM_BITS'(q_sample);
    end
    if (sq_add) begin
      sumsq_r <= sq_first ? SSQ_BITS'(sq_r) : sumsq_r + SSQ_BITS'(sq_r);
    end
  end

  // group statistics and test results
  always_ff @(posedge clk) begin
    if (state == S_FLUSH) begin
      med_r <= sorted_q[med_idx];
      nn_r  <= NN_BITS'(n_r) * NN_BITS'(n_r);
      tt_r  <= thr_r * thr_r;
    end
    if (state == S_MUL_SS) begin
      k_r <= KW'(bmof_pkg::K_SCALE * nn_r);
    end
    if (mul_done) begin
      unique case (state)
        S_MUL_SS:  ss_r  <= VW'(mul_p);
        S_MUL_NQ:  nq_r  <= VW'(mul_p);
        S_MUL_RHS: rhs_r <= mul_p;
        S_MUL_LHS: rep_r <= (mul_p >= rhs_r);
        default: begin
        end
      endcase
    end
    if (state == S_VAR) begin
      var_r <= nq_r - ss_r;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      cnt        <= '0;
      idx        <= '0;
      n_r        <= '0;
      eos_r      <= 1'b0;
      mul_issued <= 1'b0;
      sq_add     <= 1'b0;
      sq_first   <= 1'b0;
      thr_r      <= bmof_pkg::THR_RESET;
      out_valid  <= 1'b0;
      out_value  <= '0;
      out_last   <= 1'b0;
      out_user   <= '0;
    end else begin
      sq_add   <= q_pop;
      sq_first <= q_pop && (cnt == '0);
      if (cfg_valid) begin
        thr_r <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (mul_start) begin
        mul_issued <= 1'b1;
      end else if (mul_done) begin
        mul_issued <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (q_pop) begin
            if (q_flags.close) begin
              cnt   <= '0;
              n_r   <= CW'(cnt) + CW'(1);
              eos_r <= q_flags.eos;
              state <= S_FLUSH;
            end else begin
              cnt <= cnt + IW'(1);
            end
          end
        end
        S_FLUSH: begin
          state <= S_MUL_SS;
        end
        S_MUL_SS: begin
          if (mul_done) begin
            state <= S_MUL_NQ;
          end
        end
        S_MUL_NQ: begin
          if (mul_done) begin
            state <= S_VAR;
          end
        end
        S_VAR: begin
          state <= S_MUL_RHS;
        end
        S_MUL_RHS: begin
          if (mul_done) begin
            idx   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          state <= S_MUL_LHS;
        end
        S_MUL_LHS: begin
          if (mul_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid            <= 1'b1;
            out_value            <= rep_r ? med_r : x_cur;
            out_last             <= last_cur;
            out_user.replaced    <= rep_r;
            out_user.stream_done <= last_cur && eos_r;
            if (last_cur) begin
              state <= S_LOAD;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_SQ;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // the shared multiplier is never restarted while working
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  // a finished product always belongs to an issued operation
  a_done_issued: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (mul_issued && mul_state))
    else $error("multiplier result without a request");

  // emitted position stays inside the closed group
  a_emit_in_group: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (CW'(idx) < n_r))
    else $error("emit index beyond group length");

  // a closed group holds between one and a full group of samples
  a_group_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> ((n_r != '0) && (n_r <= CW'(GROUP_SIZE))))
    else $error("closed group length out of range");
`endif

endmodule

@@ rtl/block_median_outlier_filter_top.sv @@
// after a group's closing item is taken from the queue, the back end takes its median, then
//   forms variance and threshold product on the shared serial multiplier (16-bit digits)
// each item is then squared, scaled and emitted in turn; the back end pops no new item
//   from the queue until the last result of its group has been emitted
// the front end takes items into a 4-deep queue while it has room and the back end works
// reset (rst, synchronous, active high): empty queue, open group empty, threshold 110
module block_median_outlier_filter_top #(
  parameter int GROUP_SIZE  = bmof_pkg::GROUP_SIZE_DEF,
  parameter int SAMPLE_BITS = bmof_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [SAMPLE_BITS-1:0] sample, zero padded to whole bytes
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  // end_of_stream
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [SAMPLE_BITS-1:0] value, zero padded to whole bytes
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
  // last_of_group
  output logic                                 m_axis_tlast,
  // [0] replaced, [1] stream_done
  output logic [1:0]                           m_axis_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  // threshold_percent
  input  logic [bmof_pkg::THR_BITS-1:0]        cfg_data
);

  localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int QW        = SAMPLE_BITS + 2;

  logic                        push;
  logic [SAMPLE_BITS-1:0]      push_sample;
  bmof_pkg::item_flags_t       push_flags;
  logic                        q_full;
  logic                        q_empty;
  logic                        q_pop;
  logic [QW-1:0]               q_rd;
  logic [SAMPLE_BITS-1:0]      q_sample;
  bmof_pkg::item_flags_t       q_flags;
  logic [SAMPLE_BITS-1:0]      out_value;
  bmof_pkg::out_user_t         out_user;

  // intake and group bookkeeping
  bmof_front #(
    .GROUP_SIZE  (GROUP_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_sample   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_eos      (s_axis_tlast),
    .push        (push),
    .push_sample (push_sample),
    .push_flags  (push_flags),
    .q_full      (q_full)
  );

  // item queue between front and back
  bmof_fifo #(
    .WIDTH (QW),
    .DEPTH (bmof_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data ({push_flags, push_sample}),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  assign q_sample = q_rd[SAMPLE_BITS-1:0];
  assign q_flags  = bmof_pkg::item_flags_t'(q_rd[QW-1:SAMPLE_BITS]);

  // median, variance test and emission
  bmof_back #(
    .GROUP_SIZE  (GROUP_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_sample  (q_sample),
    .q_flags   (q_flags),
    .q_pop     (q_pop),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_value (out_value),
    .out_last  (m_axis_tlast),
    .out_user  (out_user)
  );

  assign m_axis_tdata = DATA_BITS'(out_value);
  assign m_axis_tuser = out_user;

endmodule

@@ tb/tb_block_median_outlier_filter_top.sv @@
module tb_block_median_outlier_filter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GROUP_N        = bmof_pkg::GROUP_SIZE_DEF;
  localparam int SAMPLE_W       = bmof_pkg::SAMPLE_BITS_DEF;
  localparam int DATA_W         = ((SAMPLE_W + 7) / 8) * 8;
  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [bmof_pkg::THR_BITS-1:0] thr_t;

  typedef struct packed {
    sample_t value;
    logic    replaced;
    logic    last_of_group;
    logic    stream_done;
  } filt_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // sample input item
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;  // [SAMPLE_W-1:0] sample
  logic              s_axis_tlast  = 1'b0;  // end_of_stream

  // filtered output item
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;  // [SAMPLE_W-1:0] value
  logic              m_axis_tlast;  // last_of_group
  logic [1:0]        m_axis_tuser;  // [0] replaced, [1] stream_done

  // threshold write channel
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  thr_t cfg_data  = '0;

  // predictor state
  sample_t      open_group[$];
  thr_t         thr_setting = bmof_pkg::THR_RESET;
  filt_result_t expected_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int samples_sent   = 0;
  int idle_cycles    = 0;

  block_median_outlier_filter_top #(
    .GROUP_SIZE (GROUP_N),
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver backpressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no item moving anywhere
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic sample_t dist_of(sample_t a, sample_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  // add one accepted sample to the open group, close it when full or at end of stream
  task automatic absorb_sample(input sample_t smp, input logic eos);
    sample_t      ordered[GROUP_N];
    sample_t      tmp;
    sample_t      med;
    logic [127:0] spread_sum;
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [127:0] d;
    int           n;
    int           k;
    filt_result_t r;
    open_group = {open_group, smp};
    if (open_group.size() < GROUP_N && !eos) return;
    n = open_group.size();
    // insertion sort over the real samples only
    for (int i = 0; i < n; i++) begin
      tmp = open_group[i];
      k = i;
      while (k > 0 && ordered[k-1] > tmp) begin
        ordered[k] = ordered[k-1];
        k--;
      end
      ordered[k] = tmp;
    end
    med = ordered[n/2];
    // n*sumsq - sum*sum as a sum of squared pair differences
    spread_sum = '0;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        d = 128'(dist_of(open_group[i], open_group[j]));
        spread_sum = spread_sum + d * d;
      end
    end
    rhs = spread_sum * 128'(thr_setting) * 128'(thr_setting);
    for (int i = 0; i < n; i++) begin
      d = 128'(dist_of(open_group[i], med));
      lhs = d * d * 128'(bmof_pkg::K_SCALE) * 128'(n) * 128'(n);
      r.replaced      = (lhs >= rhs);
      r.value         = r.replaced ? med : open_group[i];
      r.last_of_group = (i == n - 1);
      r.stream_done   = (i == n - 1) && eos;
      expected_results = {expected_results, r};
    end
    open_group.delete();
  endtask

  task automatic report_mismatch(input string what, input filt_result_t want,
                                 input filt_result_t got);
    if (mismatch_count < MAX_REPORTS) begin
      $display("%0t: %s: expected value %h rep %b last %b done %b,",
               $realtime, what, want.value, want.replaced, want.last_of_group,
               want.stream_done);
      $display("  got value %h rep %b last %b done %b",
               got.value, got.replaced, got.last_of_group, got.stream_done);
    end
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    filt_result_t        got;
    filt_result_t        want;
    bmof_pkg::out_user_t flags;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      flags             = m_axis_tuser;
      got.value         = m_axis_tdata[SAMPLE_W-1:0];
      got.replaced      = flags.replaced;
      got.last_of_group = m_axis_tlast;
      got.stream_done   = flags.stream_done;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got.value !== want.value || got.replaced !== want.replaced ||
            got.last_of_group !== want.last_of_group ||
            got.stream_done !== want.stream_done) begin
          report_mismatch("mismatch", want, got);
        end
      end
    end
  end

  // send one sample item, with random sender gaps; valid stays high afterwards
  task automatic send_sample(input sample_t smp, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'(smp);
    s_axis_tlast  <= eos;
    do @(posedge clk); while (!s_axis_tready);
    samples_sent++;
    absorb_sample(smp, eos);
  endtask

  // stop sending and wait for every outstanding result
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input thr_t thr);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    thr_setting = thr;
  endtask

  // value near a group base, with occasional outliers and extremes
  function automatic sample_t pick_sample(input sample_t base, input int unsigned spread);
    longint v;
    case ($urandom_range(11))
      0: return sample_t'($urandom);
      1: return '0;
      2: return '1;
      3: return base + sample_t'(1 << (SAMPLE_W - 1));
      default: begin
        v = longint'(base) + longint'($urandom_range(2 * spread)) - longint'(spread);
        if (v < 0) v = 0;
        if (v > (longint'(1) << SAMPLE_W) - 1) v = (longint'(1) << SAMPLE_W) - 1;
        return sample_t'(v);
      end
    endcase
  endfunction

  // one group with random content: mostly full, sometimes closed early by end of stream
  task automatic send_random_group(input bit force_eos);
    sample_t     base;
    int unsigned spread;
    bit          early;
    int          len;
    base = sample_t'($urandom);
    case ($urandom_range(4))
      0: spread = 0;
      1: spread = 3;
      2: spread = 100;
      3: spread = 3000;
      default: spread = 40000;
    endcase
    early = force_eos || ($urandom_range(5) == 0);
    len   = early ? $urandom_range(GROUP_N, 1) : GROUP_N;
    for (int i = 0; i < len; i++) begin
      send_sample(pick_sample(base, spread), early && (i == len - 1));
    end
  endtask

  // partial groups of every size closed by end of stream, at reset threshold
  task automatic test_partial_groups();
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0007, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0009, 1'b1);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0002, 1'b0);
    send_sample(16'h0003, 1'b0);
    send_sample(16'hEA60, 1'b1);
  endtask

  // full group with an outlier, constant group, end of stream on the fifth item
  task automatic test_full_and_constant_groups();
    send_sample(16'd100, 1'b0);
    send_sample(16'd101, 1'b0);
    send_sample(16'd99, 1'b0);
    send_sample(16'd100, 1'b0);
    send_sample(16'd60000, 1'b0);
    for (int i = 0; i < GROUP_N; i++) send_sample(16'h1234, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAB, 1'b1);
  endtask

  // threshold zero, top of range, one thousand, and the smallest nonzero
  task automatic test_threshold_extremes();
    thr_t corners[4] = '{thr_t'(0), thr_t'(1023), thr_t'(1000), thr_t'(1)};
    for (int c = 0; c < 4; c++) begin
      write_threshold(corners[c]);
      send_random_group(1'b0);
      send_random_group(1'b1);
    end
  endtask

  // random groups under one idling setting, with a full drain in the middle
  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items);
    int  start;
    bit  paused;
    thr_t thr;
    thr = ($urandom_range(3) == 0) ? thr_t'($urandom) : thr_t'($urandom_range(300, 50));
    write_threshold(thr);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start  = samples_sent;
    paused = 1'b0;
    while (samples_sent - start < n_items) begin
      send_random_group(1'b0);
      if (!paused && samples_sent - start >= n_items / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end
    send_random_group(1'b1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_partial_groups();
    test_full_and_constant_groups();
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    test_threshold_extremes();
    test_random_phase(0, 0, 75);
    test_random_phase(65, 0, 75);
    test_random_phase(0, 65, 75);
    test_random_phase(30, 30, 75);

    // let the block settle, catch any stray results
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
